// ===== rtl/core/brac_pkg.sv =====
// brac_pkg: shared widths, opcodes and register indexes for the bilinear resize block
// no dependencies
package brac_pkg;

  localparam int COORD_W = 7;
  localparam int STEP_W  = 23;
  localparam int PIX_W   = 16;
  localparam int SIZE_W  = 8;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;
  localparam int REG_W   = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [REG_W-1:0] REG_IN_HEIGHT = 2'd0;
  localparam logic [REG_W-1:0] REG_IN_WIDTH  = 2'd1;
  localparam logic [REG_W-1:0] REG_ROW_STEP  = 2'd2;
  localparam logic [REG_W-1:0] REG_COL_STEP  = 2'd3;

  localparam logic [SIZE_W-1:0] RST_SIZE = 8'd128;
  localparam logic [STEP_W-1:0] RST_STEP = 23'd65536;

endpackage

// ===== rtl/core/brac_cfg.sv =====
// brac_cfg: apb-style register file for plane size and step registers
// depends on brac_pkg
module brac_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brac_pkg::ADDR_W-1:0]   paddr,
  input  logic [brac_pkg::DATA_W-1:0]   pwdata,
  output logic [brac_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [brac_pkg::SIZE_W-1:0]   in_height,
  output logic [brac_pkg::SIZE_W-1:0]   in_width,
  output logic [brac_pkg::STEP_W-1:0]   row_step,
  output logic [brac_pkg::STEP_W-1:0]   col_step
);
  import brac_pkg::*;

  logic [REG_W-1:0] idx;
  logic             wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_height <= RST_SIZE;
      in_width  <= RST_SIZE;
      row_step  <= RST_STEP;
      col_step  <= RST_STEP;
    end else if (wr) begin
      unique case (idx)
        REG_IN_HEIGHT: in_height <= pwdata[SIZE_W-1:0];
        REG_IN_WIDTH:  in_width  <= pwdata[SIZE_W-1:0];
        REG_ROW_STEP:  row_step  <= pwdata[STEP_W-1:0];
        REG_COL_STEP:  col_step  <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IN_HEIGHT: prdata = DATA_W'(in_height);
      REG_IN_WIDTH:  prdata = DATA_W'(in_width);
      REG_ROW_STEP:  prdata = DATA_W'(row_step);
      REG_COL_STEP:  prdata = DATA_W'(col_step);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/brac_coord.sv =====
// brac_coord: scales one output coordinate by its step and splits it into
// source index, neighbor flag and fraction; depends on brac_pkg
module brac_coord #(
  parameter int MAX       = 128,
  parameter int FRAC_BITS = 16,
  parameter int IW        = 7
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [brac_pkg::COORD_W-1:0] coord,
  input  logic [brac_pkg::STEP_W-1:0]  step,
  input  logic [brac_pkg::SIZE_W-1:0]  size,
  output logic [IW-1:0]                idx,
  output logic                         nxt,
  output logic [FRAC_BITS-1:0]         frac
);
  import brac_pkg::*;

  localparam int PW  = COORD_W + STEP_W;
  localparam int IPW = PW - FRAC_BITS;
  localparam int SW  = $clog2(MAX + 1);

  logic [PW-1:0]  pos;
  logic [IPW-1:0] ip;
  logic [SW-1:0]  size_eff;
  logic [IW-1:0]  last;

  always_ff @(posedge clk) begin
    if (en) begin
      pos <= PW'(coord) * PW'(step);
    end
  end

  always_comb begin
    if (size == '0) begin
      size_eff = SW'(1);
    end else if (32'(size) > MAX) begin
      size_eff = SW'(MAX);
    end else begin
      size_eff = SW'(size);
    end
    last = IW'(size_eff - SW'(1));
    ip   = pos[PW-1:FRAC_BITS];
    if (32'(ip) >= 32'(last)) begin
      idx  = last;
      nxt  = 1'b0;
      frac = '0;
    end else begin
      idx  = IW'(ip);
      nxt  = 1'b1;
      frac = pos[FRAC_BITS-1:0];
    end
  end

endmodule

// ===== rtl/core/brac_bank.sv =====
// brac_bank: one parity bank of the source plane, one write and one read port
// registered read data, no dependencies
module brac_bank #(
  parameter int AW = 12,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/brac_blend.sv =====
// brac_blend: weight generation, four products and rounding of the blend
// depends on brac_pkg; bank data arrives in the cycle after the fractions
module brac_blend #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       out_en,
  input  logic [FRAC_BITS-1:0]       fr,
  input  logic [FRAC_BITS-1:0]       fc,
  input  logic                       rp,
  input  logic                       cp,
  input  logic [brac_pkg::PIX_W-1:0] pix [4],
  output logic [brac_pkg::PIX_W-1:0] result
);
  import brac_pkg::*;

  localparam int FW  = FRAC_BITS + 1;
  localparam int WW  = 2 * FRAC_BITS + 1;
  localparam int PRW = WW + PIX_W;
  localparam int AW  = 2 * FRAC_BITS + PIX_W + 1;
  localparam logic [FW-1:0]    ONE  = FW'(1) << FRAC_BITS;
  localparam logic [AW-1:0]    HALF = AW'(1) << (2 * FRAC_BITS - 1);
  localparam logic [PIX_W-1:0] BIAS = PIX_W'(1) << (PIX_W - 1);

  logic [FRAC_BITS-1:0] fr_q, fc_q;
  logic                 rp_q, cp_q;
  logic [FW-1:0]        nfr, nfc;
  logic [WW-1:0]        wt   [4];
  logic [PIX_W-1:0]     px   [4];
  logic [PRW-1:0]       prod [4];
  logic [AW-1:0]        acc;
  logic [PIX_W-1:0]     res;

  assign nfr = ONE - FW'(fr_q);
  assign nfc = ONE - FW'(fc_q);

  always_ff @(posedge clk) begin
    if (en) begin
      fr_q <= fr;
      fc_q <= fc;
      rp_q <= rp;
      cp_q <= cp;
      wt[0] <= WW'(nfr)  * WW'(nfc);
      wt[1] <= WW'(nfr)  * WW'(fc_q);
      wt[2] <= WW'(fr_q) * WW'(nfc);
      wt[3] <= WW'(fr_q) * WW'(fc_q);
      // a zero-weight neighbor may be a pixel that was never written
      px[0] <= pix[{rp_q,         cp_q}]         ^ BIAS;
      px[1] <= (fc_q == '0) ? '0 : (pix[{rp_q, ~cp_q}] ^ BIAS);
      px[2] <= (fr_q == '0) ? '0 : (pix[{~rp_q, cp_q}] ^ BIAS);
      px[3] <= (fr_q == '0 || fc_q == '0) ? '0 : (pix[{~rp_q, ~cp_q}] ^ BIAS);
      for (int k = 0; k < 4; k++) begin
        prod[k] <= PRW'(wt[k]) * PRW'(px[k]);
      end
    end
  end

  assign acc = AW'(prod[0]) + AW'(prod[1]) + AW'(prod[2]) + AW'(prod[3]) + HALF;

  always_ff @(posedge clk) begin
    if (out_en) begin
      res <= acc[2*FRAC_BITS +: PIX_W];
    end
  end

  assign result = res ^ BIAS;

endmodule

// ===== rtl/core/bilinear_resize_align_corners_top.sv =====
// bilinear_resize_align_corners_top: align-corners bilinear resize of one stored plane
// depends on brac_pkg, brac_cfg, brac_coord, brac_bank, brac_blend
//
// input channel (in_valid/in_ready) carries one word per item: op, row, col,
// pixel_value. a write word stores pixel_value at (row, col) and gives no result.
// a read word names an output pixel; its word leaves on the output channel
// (out_valid/out_ready, output_value) after the coordinate, bank, weight, product
// and output registers. throughput is one word per cycle while in_ready is high,
// writes and reads mixed freely; the four neighbors come from four row/column
// parity banks read in the same cycle. a write is committed at acceptance, so
// a read accepted in the next cycle sees it. the config port sets in_height,
// in_width, row_step, col_step; change it only idle. reset loads the default
// registers and empties the pipeline; plane contents stay undefined until written,
// there is no clearing pass. when the receiver stalls the finished word holds in the
// output register; input words are still taken while the stage ahead of the output
// register holds no read word, then the whole pipeline holds and in_ready drops.
module bilinear_resize_align_corners_top #(
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_WIDTH  = 128,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         op,
  input  logic [brac_pkg::COORD_W-1:0] row,
  input  logic [brac_pkg::COORD_W-1:0] col,
  input  logic [brac_pkg::PIX_W-1:0]   pixel_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [brac_pkg::PIX_W-1:0]   output_value,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [brac_pkg::ADDR_W-1:0]  paddr,
  input  logic [brac_pkg::DATA_W-1:0]  pwdata,
  output logic [brac_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import brac_pkg::*;

  localparam int RB  = $clog2(MAX_HEIGHT);
  localparam int CB  = $clog2(MAX_WIDTH);
  localparam int RHW = (RB > 1) ? RB - 1 : 1;
  localparam int CHW = (CB > 1) ? CB - 1 : 1;
  localparam int BAW = RHW + CHW;

  logic [SIZE_W-1:0] in_height, in_width;
  logic [STEP_W-1:0] row_step, col_step;

  logic                 v1, v2, v3, v4, ov;
  logic                 adv, out_load, acc_in, rd_acc, wr_acc;
  logic [RB-1:0]        r0, wr_r;
  logic [CB-1:0]        c0, wr_c;
  logic                 rn, cn;
  logic [FRAC_BITS-1:0] fr, fc;
  logic [RB-1:0]        rsel [2];
  logic [CB-1:0]        csel [2];
  logic [BAW-1:0]       waddr;
  logic [PIX_W-1:0]     bank_q [4];

  assign out_load = !ov || out_ready;
  assign adv      = out_load || !v4;
  assign in_ready = adv;
  assign acc_in   = in_valid && adv;
  assign rd_acc   = acc_in && (op == OP_READ);
  assign wr_acc   = acc_in && (op == OP_WRITE) &&
                    (32'(row) < MAX_HEIGHT) && (32'(col) < MAX_WIDTH);
  assign out_valid = ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (adv) begin
        v1 <= rd_acc;
        v2 <= v1;
        v3 <= v2;
        v4 <= v3;
      end
      if (out_load) begin
        ov <= v4;
      end
    end
  end

  brac_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_height (in_height),
    .in_width  (in_width),
    .row_step  (row_step),
    .col_step  (col_step)
  );

  brac_coord #(.MAX(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS), .IW(RB)) u_row (
    .clk   (clk),
    .en    (adv),
    .coord (row),
    .step  (row_step),
    .size  (in_height),
    .idx   (r0),
    .nxt   (rn),
    .frac  (fr)
  );

  brac_coord #(.MAX(MAX_WIDTH), .FRAC_BITS(FRAC_BITS), .IW(CB)) u_col (
    .clk   (clk),
    .en    (adv),
    .coord (col),
    .step  (col_step),
    .size  (in_width),
    .idx   (c0),
    .nxt   (cn),
    .frac  (fc)
  );

  // bank of parity p holds whichever of the two neighbor rows has that parity
  always_comb begin
    rsel[0] = (r0[0] == 1'b0) ? r0 : r0 + RB'(rn);
    rsel[1] = (r0[0] == 1'b1) ? r0 : r0 + RB'(rn);
    csel[0] = (c0[0] == 1'b0) ? c0 : c0 + CB'(cn);
    csel[1] = (c0[0] == 1'b1) ? c0 : c0 + CB'(cn);
  end

  assign wr_r  = RB'(row);
  assign wr_c  = CB'(col);
  assign waddr = {RHW'(wr_r >> 1), CHW'(wr_c >> 1)};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [1:0]     bsel;
    logic [BAW-1:0] raddr;
    assign bsel  = 2'(b);
    assign raddr = {RHW'(rsel[bsel[1]] >> 1), CHW'(csel[bsel[0]] >> 1)};

    brac_bank #(.AW(BAW), .DW(PIX_W)) u_bank (
      .clk   (clk),
      .we    (wr_acc && (bsel == {wr_r[0], wr_c[0]})),
      .waddr (waddr),
      .wdata (pixel_value),
      .re    (adv),
      .raddr (raddr),
      .rdata (bank_q[b])
    );
  end

  brac_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk    (clk),
    .en     (adv),
    .out_en (out_load),
    .fr     (fr),
    .fc     (fc),
    .rp     (r0[0]),
    .cp     (c0[0]),
    .pix    (bank_q),
    .result (output_value)
  );

endmodule

// ===== test/brac_scoreboard.sv =====
// brac_scoreboard: watches the word channels and the config port of the resize block
// keeps a shadow plane and register copy, predicts every read word and compares it
// depends on brac_pkg
module brac_scoreboard
  import brac_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               op,
  input  logic [COORD_W-1:0] row,
  input  logic [COORD_W-1:0] col,
  input  logic [PIX_W-1:0]   pixel_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [PIX_W-1:0]   output_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output int                 mismatches,
  output int                 pending,
  output int                 checked
);

  localparam int FRAC = 16;
  localparam int MAX_DIM = 128;
  localparam logic [63:0] ONE = 64'd1 << FRAC;

  typedef struct packed {
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
    logic [FRAC:0]      frac;
  } axis_t;

  logic [PIX_W-1:0]  plane [0:MAX_DIM*MAX_DIM-1];
  logic [SIZE_W-1:0] height_q;
  logic [SIZE_W-1:0] width_q;
  logic [STEP_W-1:0] row_step_q;
  logic [STEP_W-1:0] col_step_q;
  logic [PIX_W-1:0]  expected_pixels [$];
  logic [PIX_W-1:0]  want;

  function automatic axis_t split_axis(input logic [COORD_W-1:0] coord,
                                       input logic [STEP_W-1:0] step,
                                       input logic [SIZE_W-1:0] size);
    logic [29:0] pos;
    logic [29:0] last;
    logic [SIZE_W-1:0] eff;
    axis_t a;
    eff = (size == '0) ? 8'd1 : ((size > 8'd128) ? 8'd128 : size);
    pos = {23'd0, coord} * {7'd0, step};
    last = {22'd0, eff - 8'd1};
    if ((pos >> FRAC) >= last) begin
      a.lo = last[COORD_W-1:0];
      a.hi = last[COORD_W-1:0];
      a.frac = '0;
    end else begin
      a.lo = pos[FRAC+COORD_W-1:FRAC];
      a.hi = a.lo + 7'd1;
      a.frac = {1'b0, pos[FRAC-1:0]};
    end
    return a;
  endfunction

  // signed q8.8 pixel shifted up by half range
  function automatic logic [63:0] biased(input logic [COORD_W-1:0] r,
                                         input logic [COORD_W-1:0] c);
    logic [PIX_W-1:0] p;
    p = plane[{r, c}];
    return {48'd0, ~p[15], p[14:0]};
  endfunction

  function automatic logic [PIX_W-1:0] interpolate(input logic [COORD_W-1:0] r,
                                                   input logic [COORD_W-1:0] c);
    axis_t ay;
    axis_t ax;
    logic [63:0] fy;
    logic [63:0] fx;
    logic [63:0] acc;
    logic [63:0] res;
    ay = split_axis(r, row_step_q, height_q);
    ax = split_axis(c, col_step_q, width_q);
    fy = {47'd0, ay.frac};
    fx = {47'd0, ax.frac};
    acc = (ONE - fy) * (ONE - fx) * biased(ay.lo, ax.lo)
        + (ONE - fy) * fx * biased(ay.lo, ax.hi)
        + fy * (ONE - fx) * biased(ay.hi, ax.lo)
        + fy * fx * biased(ay.hi, ax.hi);
    res = (acc + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
    if (res > 64'd65535) res = 64'd65535;
    return res[PIX_W-1:0] ^ 16'h8000;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      height_q = RST_SIZE;
      width_q = RST_SIZE;
      row_step_q = RST_STEP;
      col_step_q = RST_STEP;
      expected_pixels.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output word %h, nothing pending", output_value);
        end else begin
          want = expected_pixels.pop_front();
          checked++;
          if (output_value !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("output_value mismatch: expected %h, actual %h", want, output_value);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (op == OP_WRITE) plane[{row, col}] = pixel_value;
        else expected_pixels.push_back(interpolate(row, col));
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_IN_HEIGHT: height_q = pwdata[SIZE_W-1:0];
          REG_IN_WIDTH:  width_q = pwdata[SIZE_W-1:0];
          REG_ROW_STEP:  row_step_q = pwdata[STEP_W-1:0];
          REG_COL_STEP:  col_step_q = pwdata[STEP_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// ===== test/tb_bilinear_resize_align_corners_top.sv =====
// tb_bilinear_resize_align_corners_top: stimulus and verdict for the bilinear resize block
// preloads the plane, runs directed and random words under several idle mixes
// depends on brac_pkg, brac_scoreboard and bilinear_resize_align_corners_top
module tb_bilinear_resize_align_corners_top;
  import brac_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               op = OP_WRITE;
  logic [COORD_W-1:0] row = '0;
  logic [COORD_W-1:0] col = '0;
  logic [PIX_W-1:0]   pixel_value = '0;
  logic               out_ready = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic               in_ready;
  logic               out_valid;
  logic [PIX_W-1:0]   output_value;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int mismatches;
  int pending;
  int checked;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int cycles = 0;
  int writes_sent = 0;
  int reads_sent = 0;
  int settings = 0;

  bilinear_resize_align_corners_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .row(row), .col(col), .pixel_value(pixel_value),
    .out_valid(out_valid), .out_ready(out_ready), .output_value(output_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  brac_scoreboard scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .row(row), .col(col), .pixel_value(pixel_value),
    .out_valid(out_valid), .out_ready(out_ready), .output_value(output_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .pending(pending), .checked(checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // output side: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  task automatic send_word(input logic o, input logic [COORD_W-1:0] r,
                           input logic [COORD_W-1:0] c, input logic [PIX_W-1:0] p);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    row <= r;
    col <= c;
    pixel_value <= p;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (o == OP_WRITE) writes_sent++;
    else reads_sent++;
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  task automatic configure(input logic [SIZE_W-1:0] h, input logic [SIZE_W-1:0] w,
                           input logic [STEP_W-1:0] rs, input logic [STEP_W-1:0] cs);
    quiesce();
    write_reg(REG_IN_HEIGHT, {24'd0, h});
    write_reg(REG_IN_WIDTH, {24'd0, w});
    write_reg(REG_ROW_STEP, {9'd0, rs});
    write_reg(REG_COL_STEP, {9'd0, cs});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    settings++;
  endtask

  // sizes stay inside the preloaded 16x16 window
  function automatic int pick_size();
    int k;
    k = $urandom_range(0, 15);
    if (k == 0) return 0;
    if (k < 6) return $urandom_range(1, 4);
    return $urandom_range(1, 16);
  endfunction

  // step is either a true align-corners ratio or any 23-bit value
  task automatic pick_axis(input int sz, output logic [STEP_W-1:0] step, output int span);
    int eff;
    eff = (sz == 0) ? 1 : ((sz > 128) ? 128 : sz);
    if ($urandom_range(0, 9) == 0) begin
      step = STEP_W'($urandom_range(0, 23'h7FFFFF));
      span = 128;
    end else begin
      span = $urandom_range(1, 128);
      step = (span == 1) ? '0 : STEP_W'(((eff - 1) * 65536) / (span - 1));
    end
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    int k;
    k = $urandom_range(0, 15);
    if (k == 0) return 16'h8000;
    if (k == 1) return 16'h7FFF;
    return PIX_W'($urandom);
  endfunction

  task automatic random_phase(input int words);
    int hsz;
    int wsz;
    int out_h;
    int out_w;
    logic [STEP_W-1:0] rs;
    logic [STEP_W-1:0] cs;
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] c;
    hsz = pick_size();
    wsz = pick_size();
    pick_axis(hsz, rs, out_h);
    pick_axis(wsz, cs, out_w);
    configure(hsz[SIZE_W-1:0], wsz[SIZE_W-1:0], rs, cs);
    for (int i = 0; i < words; i++) begin
      if ($urandom_range(0, 9) < 4) begin
        r = ($urandom_range(0, 7) == 0) ? COORD_W'($urandom_range(0, 127))
                                        : COORD_W'($urandom_range(0, 15));
        c = ($urandom_range(0, 7) == 0) ? COORD_W'($urandom_range(0, 127))
                                        : COORD_W'($urandom_range(0, 15));
        send_word(OP_WRITE, r, c, pick_pixel());
      end else begin
        r = ($urandom_range(0, 7) == 0) ? COORD_W'($urandom_range(0, 127))
                                        : COORD_W'($urandom_range(0, out_h - 1));
        c = ($urandom_range(0, 7) == 0) ? COORD_W'($urandom_range(0, 127))
                                        : COORD_W'($urandom_range(0, out_w - 1));
        send_word(OP_READ, r, c, PIX_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill the low 16x16 window; later reads stay in it or on written edge pixels
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++)
        send_word(OP_WRITE, r[COORD_W-1:0], c[COORD_W-1:0], PIX_W'($urandom));

    // corners and extreme pixels at the reset settings
    send_word(OP_WRITE, 7'd0, 7'd0, 16'h8000);
    send_word(OP_WRITE, 7'd0, 7'd1, 16'h7FFF);
    send_word(OP_WRITE, 7'd1, 7'd0, 16'h7FFF);
    send_word(OP_WRITE, 7'd1, 7'd1, 16'h8000);
    send_word(OP_WRITE, 7'd127, 7'd127, 16'h7FFF);
    send_word(OP_WRITE, 7'd127, 7'd0, 16'h8000);
    send_word(OP_WRITE, 7'd64, 7'd0, 16'h1234);
    send_word(OP_READ, 7'd0, 7'd0, 16'h0000);
    send_word(OP_READ, 7'd127, 7'd127, 16'hFFFF);
    send_word(OP_READ, 7'd64, 7'd0, 16'h0000);
    send_word(OP_READ, 7'd0, 7'd1, 16'h0000);

    // fractional blend, edge neighbor and index past the edge
    configure(8'd4, 8'd4, 23'h018000, 23'h008000);
    send_word(OP_READ, 7'd1, 7'd1, 16'h0000);
    send_word(OP_READ, 7'd2, 7'd3, 16'h0000);
    send_word(OP_READ, 7'd3, 7'd6, 16'h0000);
    send_word(OP_READ, 7'd1, 7'd7, 16'h0000);
    send_word(OP_READ, 7'd127, 7'd127, 16'h0000);

    // out-of-range sizes and extreme steps
    configure(8'd0, 8'd200, 23'h7FFFFF, 23'd0);
    send_word(OP_READ, 7'd127, 7'd127, 16'h0000);
    send_word(OP_READ, 7'd0, 7'd5, 16'h0000);
    configure(8'd128, 8'd1, 23'h7F0000, 23'h7FFFFF);
    send_word(OP_READ, 7'd1, 7'd0, 16'h0000);
    send_word(OP_READ, 7'd127, 7'd127, 16'h0000);

    // read right after a write to the same pixel, then half-way ties
    configure(8'd2, 8'd2, 23'h010000, 23'h010000);
    send_word(OP_WRITE, 7'd1, 7'd1, 16'h7FFF);
    send_word(OP_READ, 7'd1, 7'd1, 16'h0000);
    send_word(OP_WRITE, 7'd0, 7'd1, 16'h0001);
    send_word(OP_READ, 7'd0, 7'd1, 16'h0000);
    configure(8'd2, 8'd2, 23'h008000, 23'h008000);
    send_word(OP_READ, 7'd1, 7'd1, 16'h0000);
    send_word(OP_READ, 7'd1, 7'd0, 16'h0000);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 68; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 68; end
        default: begin send_idle = 27; recv_stall = 27; end
      endcase
      random_phase(60);
      random_phase(60);
    end

    // long output hold-off while reads keep coming, so the pipeline backs up
    send_idle = 0;
    recv_stall = 0;
    configure(8'd16, 8'd16, 23'h008000, 23'h00C000);
    in_valid <= 1'b0;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    for (int i = 0; i < 60; i++)
      send_word(OP_READ, COORD_W'($urandom_range(0, 31)), COORD_W'($urandom_range(0, 21)),
                PIX_W'($urandom));

    quiesce();
    $display("covered %0d pixel writes and %0d interpolated reads over %0d register settings",
             writes_sent, reads_sent, settings);
    $display("%0d output words checked under four idle mixes and one long output hold-off",
             checked);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
